FILE: rtl/cwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex window average package
// Shared constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package cwa_pkg;

	localparam int DefMaxWindow   = 64;
	localparam int DefSampleBits  = 16;
	localparam int DefCordicSteps = 16;
	localparam int AtanEntries    = 24;
	localparam int AngBits        = 34;

	localparam logic [6:0]  WinLenReset   = 7'd64;
	localparam logic [15:0] MagLimReset   = 16'd41;
	localparam logic [15:0] PhaseLimReset = 16'd328;

	// Configuration register indexes.
	localparam logic [1:0] RegWinLen   = 2'd0;
	localparam logic [1:0] RegMagLim   = 2'd1;
	localparam logic [1:0] RegPhaseLim = 2'd2;

	// Command codes.
	localparam logic CmdAdd   = 1'b0;
	localparam logic CmdClear = 1'b1;

	// Arctangent of 2^-i in units of pi/2^31.
	function automatic logic signed [AngBits-1:0] atan_lut(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0: v = 32'h20000000; 5'd1: v = 32'h12E4051E; 5'd2: v = 32'h09FB385B;
			5'd3: v = 32'h051111D4; 5'd4: v = 32'h028B0D43; 5'd5: v = 32'h0145D7E1;
			5'd6: v = 32'h00A2F61E; 5'd7: v = 32'h00517C55; 5'd8: v = 32'h0028BE53;
			5'd9: v = 32'h00145F2F; 5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518; 5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146; 5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return $signed({2'b00, v});
	endfunction

endpackage

FILE: rtl/cwa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window front end
// Accepts items, keeps the sample ring, running sums and fill count, and
// pushes one snapshot per item into the job register.
// ----------------------------------------------------------------------------
module cwa_front #(
	parameter int MAX_WINDOW  = cwa_pkg::DefMaxWindow,
	parameter int SAMPLE_BITS = cwa_pkg::DefSampleBits,
	localparam int SlotBits   = $clog2(MAX_WINDOW),
	localparam int CntBits    = $clog2(MAX_WINDOW + 1),
	localparam int SumBits    = SAMPLE_BITS + SlotBits
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic signed [SAMPLE_BITS-1:0] sample_re,
	input  logic signed [SAMPLE_BITS-1:0] sample_im,
	input  logic [6:0]                    win_len,
	output logic                          job_valid,
	input  logic                          job_ready,
	output logic signed [SumBits-1:0]     job_sum_re,
	output logic signed [SumBits-1:0]     job_sum_im,
	output logic signed [SAMPLE_BITS-1:0] job_lat_re,
	output logic signed [SAMPLE_BITS-1:0] job_lat_im,
	output logic [CntBits-1:0]            job_count,
	output logic                          job_full
);
	import cwa_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_READ, F_UPDATE, F_PUSH} fstate_t;

	fstate_t                   state_q;
	logic                      cmd_q;
	logic signed [SAMPLE_BITS-1:0] re_q, im_q;
	logic signed [SAMPLE_BITS-1:0] ring_re [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] ring_im [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] old_re_q, old_im_q;
	logic signed [SumBits-1:0] sum_re_q, sum_im_q;
	logic [CntBits-1:0]        fill_q;
	logic [SlotBits-1:0]       slot_q;
	logic [CntBits-1:0]        eff_len;
	logic [SlotBits-1:0]       old_slot;
	logic                      at_len;

	// Clamp the window length into one to MAX_WINDOW.
	always_comb begin
		if (win_len == 7'd0) begin
			eff_len = CntBits'(1);
		end else if (32'(win_len) > MAX_WINDOW) begin
			eff_len = CntBits'(MAX_WINDOW);
		end else begin
			eff_len = CntBits'(win_len);
		end
	end

	// The oldest sample sits fill_q slots behind the write slot, modulo the ring depth.
	assign at_len   = fill_q >= eff_len;
	assign old_slot = (32'(slot_q) >= 32'(fill_q))
		? SlotBits'(32'(slot_q) - 32'(fill_q))
		: SlotBits'(32'(slot_q) + MAX_WINDOW - 32'(fill_q));
	assign in_ready = (state_q == F_IDLE);

	// Ring writes happen in the update step.
	always_ff @(posedge clk) begin
		if (state_q == F_READ) begin
			old_re_q <= ring_re[old_slot];
			old_im_q <= ring_im[old_slot];
		end
		if (state_q == F_UPDATE && cmd_q == CmdAdd) begin
			ring_re[slot_q] <= re_q;
			ring_im[slot_q] <= im_q;
		end
	end

	// Newest sample comes from the item register: it was just written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			job_valid <= 1'b0;
			sum_re_q  <= '0;
			sum_im_q  <= '0;
			fill_q    <= '0;
			slot_q    <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						cmd_q   <= cmd;
						re_q    <= sample_re;
						im_q    <= sample_im;
						state_q <= F_READ;
					end
				end
				F_READ: state_q <= F_UPDATE;
				F_UPDATE: begin
					if (cmd_q == CmdClear) begin
						sum_re_q <= '0;
						sum_im_q <= '0;
						fill_q   <= '0;
						slot_q   <= '0;
						job_sum_re <= '0;
						job_sum_im <= '0;
						job_count  <= '0;
						job_full   <= 1'b0;
						job_lat_re <= '0;
						job_lat_im <= '0;
					end else begin
						logic signed [SumBits-1:0] nre, nim;
						logic [CntBits-1:0] ncnt;
						nre  = sum_re_q + SumBits'(re_q)
							- (at_len ? SumBits'(old_re_q) : '0);
						nim  = sum_im_q + SumBits'(im_q)
							- (at_len ? SumBits'(old_im_q) : '0);
						ncnt = at_len ? fill_q : fill_q + 1'b1;
						sum_re_q   <= nre;
						sum_im_q   <= nim;
						fill_q     <= ncnt;
						slot_q     <= (32'(slot_q) == MAX_WINDOW - 1) ? '0 : slot_q + 1'b1;
						job_sum_re <= nre;
						job_sum_im <= nim;
						job_count  <= ncnt;
						job_full   <= ncnt >= eff_len;
						job_lat_re <= (ncnt > CntBits'(1)) ? re_q : '0;
						job_lat_im <= (ncnt > CntBits'(1)) ? im_q : '0;
					end
					job_valid <= 1'b1;
					state_q   <= F_PUSH;
				end
				F_PUSH: begin
					if (job_ready) begin
						job_valid <= 1'b0;
						state_q   <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// A pushed snapshot never has a newest sample without two held.
	assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_count < CntBits'(2) |-> job_lat_re == '0 && job_lat_im == '0)
		else $error("newest sample shown with fewer than two held");
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CntBits'(MAX_WINDOW))
		else $error("fill count beyond ring depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && !job_ready |=> job_valid && $stable(job_sum_re))
		else $error("queued snapshot dropped");

endmodule

FILE: rtl/cwa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Settle check back end
// Divides the sums by the count one bit a cycle, runs one shared CORDIC over
// average and newest sample if a check is due; holds the result for output.
// ----------------------------------------------------------------------------
module cwa_back #(
	parameter int MAX_WINDOW   = cwa_pkg::DefMaxWindow,
	parameter int SAMPLE_BITS  = cwa_pkg::DefSampleBits,
	parameter int CORDIC_STEPS = cwa_pkg::DefCordicSteps,
	localparam int SlotBits    = $clog2(MAX_WINDOW),
	localparam int CntBits     = $clog2(MAX_WINDOW + 1),
	localparam int SumBits     = SAMPLE_BITS + SlotBits
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	output logic                          job_ready,
	input  logic signed [SumBits-1:0]     job_sum_re,
	input  logic signed [SumBits-1:0]     job_sum_im,
	input  logic signed [SAMPLE_BITS-1:0] job_lat_re,
	input  logic signed [SAMPLE_BITS-1:0] job_lat_im,
	input  logic [CntBits-1:0]            job_count,
	input  logic                          job_full,
	input  logic [15:0]                   mag_lim,
	input  logic [15:0]                   phase_lim,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] avg_re,
	output logic signed [SAMPLE_BITS-1:0] avg_im,
	output logic signed [SAMPLE_BITS-1:0] latest_re,
	output logic signed [SAMPLE_BITS-1:0] latest_im,
	output logic [CntBits-1:0]            held_count,
	output logic                          window_full,
	output logic                          settled
);
	import cwa_pkg::*;

	localparam int Steps  = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;
	localparam int StBits = $clog2(((SumBits > Steps) ? SumBits : Steps) + 1);
	localparam int VBits  = SAMPLE_BITS + 3;
	localparam int MBits  = VBits + 17;

	typedef enum logic [2:0] {
		B_IDLE, B_DIV, B_LOAD, B_COR_A, B_COR_L, B_CMP, B_OUT
	} bstate_t;

	bstate_t                  state_q;
	logic [SumBits-1:0]       rem_re_q, rem_im_q, quo_re_q, quo_im_q;
	logic [SumBits-1:0]       num_re_q, num_im_q;
	logic                     neg_re_q, neg_im_q;
	logic [CntBits-1:0]       div_q;
	logic [StBits-1:0]        step_q;
	logic signed [VBits-1:0]  x_q, y_q;
	logic signed [AngBits-1:0] z_q, pa_q;
	logic signed [VBits-1:0]  ma_q;
	logic                     chk_q;

	// One restoring division bit for a magnitude.
	function automatic logic [2*SumBits-1:0] div_bit(input logic [SumBits-1:0] rem,
			input logic [SumBits-1:0] num, input logic [SumBits-1:0] quo,
			input logic [CntBits-1:0] d, input logic [StBits-1:0] k);
		logic [SumBits:0] r;
		logic [SumBits-1:0] q;
		r = {rem, num[k]};
		q = quo;
		if (r >= (SumBits+1)'(d)) begin
			r = r - (SumBits+1)'(d);
			q[k] = 1'b1;
		end
		return {r[SumBits-1:0], q};
	endfunction

	logic [2*SumBits-1:0] dre, dim;
	assign dre = div_bit(rem_re_q, num_re_q, quo_re_q, div_q, step_q);
	assign dim = div_bit(rem_im_q, num_im_q, quo_im_q, div_q, step_q);

	logic signed [SAMPLE_BITS-1:0] qre, qim;
	assign qre = neg_re_q ? -SAMPLE_BITS'(quo_re_q) : SAMPLE_BITS'(quo_re_q);
	assign qim = neg_im_q ? -SAMPLE_BITS'(quo_im_q) : SAMPLE_BITS'(quo_im_q);

	// Prerotation of a vector with negative real part.
	function automatic logic [2*VBits+AngBits-1:0] pre_rot(
			input logic signed [SAMPLE_BITS-1:0] re, input logic signed [SAMPLE_BITS-1:0] im);
		logic signed [VBits-1:0] x, y;
		logic signed [AngBits-1:0] z;
		x = VBits'(re);
		y = VBits'(im);
		z = '0;
		if (re < 0) begin
			if (im >= 0) begin
				x = VBits'(im); y = -VBits'(re); z = AngBits'(64'sd1 <<< 30);
			end else begin
				x = -VBits'(im); y = VBits'(re); z = -AngBits'(64'sd1 <<< 30);
			end
		end
		return {x, y, z};
	endfunction

	logic signed [VBits-1:0] nx, ny;
	logic signed [AngBits-1:0] nz;
	always_comb begin
		if (y_q >= 0) begin
			nx = x_q + (y_q >>> step_q);
			ny = y_q - (x_q >>> step_q);
			nz = z_q + atan_lut(5'(step_q));
		end else begin
			nx = x_q - (y_q >>> step_q);
			ny = y_q + (x_q >>> step_q);
			nz = z_q - atan_lut(5'(step_q));
		end
	end

	logic signed [MBits-1:0]   dm;
	logic signed [AngBits-1:0] dp;
	logic [MBits-1:0] lhs, rhs;
	logic [AngBits+1:0] plim;
	assign dm   = MBits'(ma_q) - MBits'(x_q);
	assign lhs  = MBits'(dm < 0 ? -dm : dm) << 12;
	assign rhs  = MBits'(mag_lim) * MBits'(x_q);
	assign dp   = pa_q - z_q;
	assign plim = (AngBits+2)'(phase_lim) << 16;

	assign job_ready = (state_q == B_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						neg_re_q   <= job_sum_re < 0;
						neg_im_q   <= job_sum_im < 0;
						num_re_q   <= job_sum_re < 0 ? -job_sum_re : job_sum_re;
						num_im_q   <= job_sum_im < 0 ? -job_sum_im : job_sum_im;
						rem_re_q   <= '0;
						rem_im_q   <= '0;
						quo_re_q   <= '0;
						quo_im_q   <= '0;
						div_q      <= job_count;
						step_q     <= StBits'(SumBits - 1);
						latest_re  <= job_lat_re;
						latest_im  <= job_lat_im;
						held_count <= job_count;
						window_full <= job_full;
						chk_q      <= job_full && job_count > CntBits'(1);
						state_q    <= B_DIV;
					end
				end
				B_DIV: begin
					if (div_q == '0) begin
						state_q <= B_CMP;
						chk_q   <= 1'b0;
						quo_re_q <= '0;
						quo_im_q <= '0;
						neg_re_q <= 1'b0;
						neg_im_q <= 1'b0;
					end else begin
						rem_re_q <= dre[2*SumBits-1:SumBits];
						quo_re_q <= dre[SumBits-1:0];
						rem_im_q <= dim[2*SumBits-1:SumBits];
						quo_im_q <= dim[SumBits-1:0];
						if (step_q == '0) begin
							state_q <= chk_q ? B_LOAD : B_CMP;
						end else begin
							step_q <= step_q - 1'b1;
						end
					end
				end
				// Load the average; a zero average has magnitude and angle zero.
				B_LOAD: begin
					step_q <= '0;
					if (qre == 0 && qim == 0) begin
						ma_q <= '0; pa_q <= '0;
						{x_q, y_q, z_q} <= pre_rot(latest_re, latest_im);
						state_q <= B_COR_L;
					end else begin
						{x_q, y_q, z_q} <= pre_rot(qre, qim);
						state_q <= B_COR_A;
					end
				end
				B_COR_A: begin
					if (step_q == StBits'(Steps - 1)) begin
						ma_q <= nx; pa_q <= nz;
						{x_q, y_q, z_q} <= pre_rot(latest_re, latest_im);
						step_q <= '0;
						state_q <= B_COR_L;
					end else begin
						x_q <= nx; y_q <= ny; z_q <= nz;
						step_q <= step_q + 1'b1;
					end
				end
				B_COR_L: begin
					if (latest_re == 0 && latest_im == 0) begin
						x_q <= '0; z_q <= '0;
						state_q <= B_CMP;
					end else begin
						x_q <= nx; y_q <= ny; z_q <= nz;
						if (step_q == StBits'(Steps - 1)) begin
							state_q <= B_CMP;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				B_CMP: begin
					avg_re    <= qre;
					avg_im    <= qim;
					settled   <= chk_q && (x_q > 0) && (lhs < rhs)
						&& ((AngBits+2)'(dp < 0 ? -dp : dp) < plim);
					out_valid <= 1'b1;
					state_q   <= B_OUT;
				end
				B_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == B_OUT)
		else $error("result shown outside output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && settled |-> window_full && held_count > CntBits'(1))
		else $error("settled without a full window");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && held_count == '0 |-> avg_re == '0 && avg_im == '0)
		else $error("nonzero average of empty window");

endmodule

FILE: rtl/complex_window_average_settle_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex window average with settle check
// Sliding-window average of complex samples and a magnitude/phase settle flag.
// ----------------------------------------------------------------------------
// One item at a time per side. The front end takes an item through accept,
// ring read, sum update and push into a one-entry job register, and waits
// there until the back end takes the job. The back end takes the job, runs
// the bit-serial divider, loads the CORDIC, runs it over the average and the
// newest sample, compares and holds the result until it is taken. The CORDIC
// runs only when the window is full with two or more samples, and skips the
// average when it is zero; a clear does no division. The back end sets the
// rate; the front end overlaps with it through the job register.
module complex_window_average_settle_check #(
	parameter int MAX_WINDOW   = cwa_pkg::DefMaxWindow,
	parameter int SAMPLE_BITS  = cwa_pkg::DefSampleBits,
	parameter int CORDIC_STEPS = cwa_pkg::DefCordicSteps
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic signed [SAMPLE_BITS-1:0] sample_re,
	input  logic signed [SAMPLE_BITS-1:0] sample_im,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [15:0]                   cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] avg_re,
	output logic signed [SAMPLE_BITS-1:0] avg_im,
	output logic signed [SAMPLE_BITS-1:0] latest_re,
	output logic signed [SAMPLE_BITS-1:0] latest_im,
	output logic [$clog2(MAX_WINDOW+1)-1:0] held_count,
	output logic                          window_full,
	output logic                          settled
);
	import cwa_pkg::*;

	localparam int CntBits = $clog2(MAX_WINDOW + 1);
	localparam int SumBits = SAMPLE_BITS + $clog2(MAX_WINDOW);

	logic [6:0]  win_len_q;
	logic [15:0] mag_lim_q, phase_lim_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q   <= WinLenReset;
			mag_lim_q   <= MagLimReset;
			phase_lim_q <= PhaseLimReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegWinLen:   win_len_q   <= cfg_data[6:0];
				RegMagLim:   mag_lim_q   <= cfg_data;
				RegPhaseLim: phase_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic                      job_valid, job_ready, job_full;
	logic signed [SumBits-1:0] job_sum_re, job_sum_im;
	logic signed [SAMPLE_BITS-1:0] job_lat_re, job_lat_im;
	logic [CntBits-1:0]        job_count;

	cwa_front #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .cmd, .sample_re, .sample_im,
		.win_len(win_len_q), .job_valid, .job_ready, .job_sum_re, .job_sum_im,
		.job_lat_re, .job_lat_im, .job_count, .job_full
	);

	cwa_back #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job_sum_re, .job_sum_im,
		.job_lat_re, .job_lat_im, .job_count, .job_full,
		.mag_lim(mag_lim_q), .phase_lim(phase_lim_q), .out_valid, .out_ready,
		.avg_re, .avg_im, .latest_re, .latest_im, .held_count, .window_full, .settled
	);

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex window average testbench
// Drives add and clear items through the valid/ready input, predicts each
// window average, count, full flag and CORDIC-based settle flag in a local
// model of the window, and compares every result item in order. A directed
// table comes first, then random phases under several register settings and
// idle patterns, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
	import cwa_pkg::*;

	localparam int  Depth       = 64;
	localparam int  CordicIters = 16;
	localparam int  RandomItems = 1340;
	localparam int  DrainCycles = 100;
	localparam longint CycleLimit = 1500000;
	localparam longint QuarterTurn = 64'sd1 << 30;

	localparam longint AtanTurns[24] = '{
		'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
		'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
		'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
		'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051
	};

	typedef struct packed {
		logic signed [15:0] avg_re;
		logic signed [15:0] avg_im;
		logic signed [15:0] latest_re;
		logic signed [15:0] latest_im;
		logic [6:0]         held;
		logic               full;
		logic               settled;
	} window_report_t;

	typedef enum logic {RowItem, RowReg} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [1:0]         reg_index;
		logic [15:0]        reg_value;
		logic               op;
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               typed;
		window_report_t     want;
	} stim_row_t;

	localparam window_report_t Empty = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CmdAdd;
	logic signed [15:0] sample_re = '0;
	logic signed [15:0] sample_im = '0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = RegWinLen;
	logic [15:0] cfg_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] avg_re, avg_im, latest_re, latest_im;
	logic [6:0] held_count;
	logic window_full, settled;

	// Local copy of the window state and registers.
	logic signed [15:0] win_re[Depth];
	logic signed [15:0] win_im[Depth];
	longint acc_re, acc_im;
	int unsigned held, slot;
	int unsigned win_len_reg, mag_lim_reg, phase_lim_reg;

	window_report_t pending_reports[$];
	int  errors = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	logic holding = 1'b0;
	logic start_hold = 1'b0;
	longint cycles = 0;

	complex_window_average_settle_check uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .sample_re(sample_re), .sample_im(sample_im),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.avg_re(avg_re), .avg_im(avg_im), .latest_re(latest_re), .latest_im(latest_im),
		.held_count(held_count), .window_full(window_full), .settled(settled)
	);

	always #1 clk = ~clk;

	// Cycle count and run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// CORDIC vectoring: unscaled magnitude and angle in units of pi/2^31.
	function automatic void cordic_polar(input longint xi, input longint yi,
			output longint mag, output longint ang);
		longint x, y, z, t, dx, dy;
		x = xi;
		y = yi;
		z = 0;
		if (x == 0 && y == 0) begin
			mag = 0;
			ang = 0;
			return;
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = QuarterTurn;
			end else begin
				x = -y; y = t; z = -QuarterTurn;
			end
		end
		for (int i = 0; i < CordicIters; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += AtanTurns[i];
			end else begin
				x -= dx; y += dy; z -= AtanTurns[i];
			end
		end
		mag = x;
		ang = z;
	endfunction

	// Updates the window with one item and returns the report it causes.
	function automatic window_report_t window_step(logic op, logic signed [15:0] re,
			logic signed [15:0] im);
		window_report_t r;
		int unsigned len, oldest, last;
		longint ma, pa, ml, pl, dm, dp;
		r = Empty;
		len = (win_len_reg < 1) ? 1 : (win_len_reg > Depth) ? Depth : win_len_reg;
		if (op == CmdClear) begin
			acc_re = 0; acc_im = 0; held = 0; slot = 0;
		end else begin
			if (held >= len) begin
				oldest = (slot + Depth - held) % Depth;
				acc_re -= win_re[oldest];
				acc_im -= win_im[oldest];
			end else begin
				held++;
			end
			win_re[slot] = re;
			win_im[slot] = im;
			acc_re += re;
			acc_im += im;
			slot = (slot + 1) % Depth;
		end
		if (held > 0) begin
			r.avg_re = 16'(acc_re / longint'(held));
			r.avg_im = 16'(acc_im / longint'(held));
		end
		r.full = held >= len;
		r.held = 7'(held);
		if (held > 1) begin
			last = (slot + Depth - 1) % Depth;
			r.latest_re = win_re[last];
			r.latest_im = win_im[last];
			if (r.full) begin
				cordic_polar(r.avg_re, r.avg_im, ma, pa);
				cordic_polar(r.latest_re, r.latest_im, ml, pl);
				dm = (ma > ml) ? ma - ml : ml - ma;
				dp = (pa > pl) ? pa - pl : pl - pa;
				r.settled = ml > 0 && dm * 4096 < longint'(mag_lim_reg) * ml
					&& dp < longint'(phase_lim_reg) * 65536;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
		errors++;
	endtask

	// Result checking against the oldest pending report.
	always @(posedge clk) begin
		window_report_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$display("[%0t] result item with no pending expectation", $time);
				errors++;
			end else begin
				w = pending_reports.pop_front();
				if (avg_re !== w.avg_re) report_mismatch("avg_re", avg_re, w.avg_re);
				if (avg_im !== w.avg_im) report_mismatch("avg_im", avg_im, w.avg_im);
				if (latest_re !== w.latest_re)
					report_mismatch("latest_re", latest_re, w.latest_re);
				if (latest_im !== w.latest_im)
					report_mismatch("latest_im", latest_im, w.latest_im);
				if (held_count !== w.held) report_mismatch("held_count", held_count, w.held);
				if (window_full !== w.full)
					report_mismatch("window_full", window_full, w.full);
				if (settled !== w.settled) report_mismatch("settled", settled, w.settled);
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when requested.
	always @(posedge clk) begin
		out_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
	end

	// Long hold-off, counted here while the sender keeps offering items.
	initial begin
		wait (start_hold);
		@(posedge clk);
		holding <= 1'b1;
		repeat (600) @(posedge clk);
		holding <= 1'b0;
	end

	// Offers one item, with random idle cycles before it, and predicts its report.
	task automatic send_item(logic op, logic signed [15:0] re, logic signed [15:0] im,
			logic typed, window_report_t want);
		window_report_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		cmd <= op;
		sample_re <= re;
		sample_im <= im;
		do @(posedge clk); while (!in_ready);
		r = window_step(op, re, im);
		pending_reports.push_back(typed ? want : r);
	endtask

	// Stops offering and waits until every report has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Writes one register; the caller lowers the write enable afterwards.
	task automatic write_reg(logic [1:0] index, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		case (index)
			RegWinLen:   win_len_reg = 32'(value & 16'h7F);
			RegMagLim:   mag_lim_reg = 32'(value);
			RegPhaseLim: phase_lim_reg = 32'(value);
			default: ;
		endcase
	endtask

	function automatic logic signed [15:0] clip16(int v);
		return (v > 32767) ? 16'sd32767 : (v < -32768) ? -16'sd32768 : 16'(v);
	endfunction

	stim_row_t directed_rows[];

	initial begin
		int per_phase, noise, base_re, base_im, sent, pick;
		logic signed [15:0] re, im;
		win_len_reg = 32'(WinLenReset);
		mag_lim_reg = 32'(MagLimReset);
		phase_lim_reg = 32'(PhaseLimReset);
		acc_re = 0; acc_im = 0; held = 0; slot = 0;
		directed_rows = '{
			'{RowItem, RegWinLen, 16'd0, CmdClear, 16'sd0, 16'sd0, 1'b1, Empty},
			'{RowItem, RegWinLen, 16'd0, CmdAdd, 16'sd32767, -16'sd32768, 1'b1,
				'{16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 7'd1, 1'b0, 1'b0}},
			'{RowItem, RegWinLen, 16'd0, CmdAdd, -16'sd32768, 16'sd32767, 1'b1,
				'{16'sd0, 16'sd0, -16'sd32768, 16'sd32767, 7'd2, 1'b0, 1'b0}},
			'{RowItem, RegWinLen, 16'd0, CmdAdd, 16'sd0, 16'sd0, 1'b1,
				'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 7'd3, 1'b0, 1'b0}},
			'{RowItem, RegWinLen, 16'd0, CmdClear, 16'sd0, 16'sd0, 1'b1, Empty},
			'{RowReg, RegWinLen, 16'd2, CmdAdd, 16'sd0, 16'sd0, 1'b0, Empty},
			'{RowItem, RegWinLen, 16'd0, CmdAdd, 16'sd1000, -16'sd1000, 1'b1,
				'{16'sd1000, -16'sd1000, 16'sd0, 16'sd0, 7'd1, 1'b0, 1'b0}},
			// Identical samples in a full window settle.
			'{RowItem, RegWinLen, 16'd0, CmdAdd, 16'sd1000, -16'sd1000, 1'b0, Empty},
			// A zero newest sample never settles.
			'{RowItem, RegWinLen, 16'd0, CmdAdd, 16'sd0, 16'sd0, 1'b0, Empty},
			'{RowItem, RegWinLen, 16'd0, CmdAdd, 16'sd0, 16'sd0, 1'b0, Empty},
			// Negative real parts take the quarter-turn pre-rotation.
			'{RowItem, RegWinLen, 16'd0, CmdAdd, -16'sd20000, 16'sd5, 1'b0, Empty},
			'{RowItem, RegWinLen, 16'd0, CmdAdd, -16'sd20000, -16'sd5, 1'b0, Empty},
			// Shrinking the window without a clear keeps the held count.
			'{RowReg, RegWinLen, 16'd1, CmdAdd, 16'sd0, 16'sd0, 1'b0, Empty},
			'{RowItem, RegWinLen, 16'd0, CmdAdd, 16'sd5, 16'sd5, 1'b0, Empty},
			'{RowItem, RegWinLen, 16'd0, CmdClear, 16'sd0, 16'sd0, 1'b1, Empty},
			// A window of one is full but never settled.
			'{RowItem, RegWinLen, 16'd0, CmdAdd, 16'sd7, 16'sd7, 1'b1,
				'{16'sd7, 16'sd7, 16'sd0, 16'sd0, 7'd1, 1'b1, 1'b0}},
			// Zero length clamps to one; widest limits.
			'{RowReg, RegWinLen, 16'd0, CmdAdd, 16'sd0, 16'sd0, 1'b0, Empty},
			'{RowReg, RegMagLim, 16'hFFFF, CmdAdd, 16'sd0, 16'sd0, 1'b0, Empty},
			'{RowReg, RegPhaseLim, 16'hFFFF, CmdAdd, 16'sd0, 16'sd0, 1'b0, Empty},
			'{RowItem, RegWinLen, 16'd0, CmdAdd, -16'sd1, -16'sd1, 1'b0, Empty},
			// Oversized length clamps to the full ring; zero limits.
			'{RowReg, RegWinLen, 16'd127, CmdAdd, 16'sd0, 16'sd0, 1'b0, Empty},
			'{RowReg, RegMagLim, 16'd0, CmdAdd, 16'sd0, 16'sd0, 1'b0, Empty},
			'{RowReg, RegPhaseLim, 16'd0, CmdAdd, 16'sd0, 16'sd0, 1'b0, Empty},
			'{RowItem, RegWinLen, 16'd0, CmdClear, 16'sd0, 16'sd0, 1'b1, Empty},
			'{RowItem, RegWinLen, 16'd0, CmdAdd, 16'sd100, 16'sd100, 1'b0, Empty}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == RowReg) begin
				drain();
				write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
				cfg_we <= 1'b0;
			end else begin
				send_item(directed_rows[i].op, directed_rows[i].re, directed_rows[i].im,
					directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// Random phases: new settings, idle pattern and target vector each time.
		per_phase = RandomItems / 8;
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case ($urandom_range(5))
				0: write_reg(RegWinLen, 16'd64);
				1: write_reg(RegWinLen, 16'($urandom_range(127)));
				default: write_reg(RegWinLen, 16'($urandom_range(12, 1)));
			endcase
			case ($urandom_range(3))
				0: write_reg(RegMagLim, 16'hFFFF);
				1: write_reg(RegMagLim, 16'($urandom_range(65535)));
				default: write_reg(RegMagLim, 16'($urandom_range(400)));
			endcase
			case ($urandom_range(3))
				0: write_reg(RegPhaseLim, 16'hFFFF);
				1: write_reg(RegPhaseLim, 16'($urandom_range(65535)));
				default: write_reg(RegPhaseLim, 16'($urandom_range(3000)));
			endcase
			cfg_we <= 1'b0;
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			if (ph == 4) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
				start_hold <= 1'b1;
			end
			// Usually start from an empty window; sometimes keep the old contents.
			if ($urandom_range(3) != 0)
				send_item(CmdClear, 16'sd0, 16'sd0, 1'b0, Empty);
			base_re = $signed(16'($urandom_range(65535))) / 2;
			base_im = $signed(16'($urandom_range(65535))) / 2;
			case ($urandom_range(3))
				0: noise = 0;
				1: noise = 4;
				2: noise = 64;
				default: noise = 2000;
			endcase
			sent = 0;
			while (sent < per_phase) begin
				pick = $urandom_range(99);
				if (pick < 4) begin
					send_item(CmdClear, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
						1'b0, Empty);
				end else if (pick < 12) begin
					re = 16'($urandom_range(65535));
					im = 16'($urandom_range(65535));
					send_item(CmdAdd, re, im, 1'b0, Empty);
				end else begin
					re = clip16(base_re + $signed($urandom_range(2 * noise)) - noise);
					im = clip16(base_im + $signed($urandom_range(2 * noise)) - noise);
					send_item(CmdAdd, re, im, 1'b0, Empty);
				end
				sent++;
			end
		end

		drain();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/cwa_pkg.sv
rtl/cwa_front.sv
rtl/cwa_back.sv
rtl/complex_window_average_settle_check.sv
tb/tb.sv
